// ----- design/fbvr_pkg.sv -----
// Shared types, codes and defaults for the framebuffer video register block.
package fbvr_pkg;

  // Default address map and sizes
  localparam int unsigned VRAM_BYTES_DEF      = 65536;
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned VRAM_BASE_DEF       = 0;
  localparam int unsigned PALETTE_BASE_DEF    = 65536;
  localparam int unsigned REG_BASE_DEF        = 66048;

  // Request kinds carried on s_tuser
  localparam logic [2:0] REQ_RD_BYTE = 3'd0;
  localparam logic [2:0] REQ_RD_WORD = 3'd1;
  localparam logic [2:0] REQ_WR_BYTE = 3'd2;
  localparam logic [2:0] REQ_WR_WORD = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_CYCLES_PER_FRAME = 2'd0;
  localparam logic [1:0] CFG_IRQ_LEVEL        = 2'd1;
  localparam logic [1:0] CFG_FRAME_WIDTH      = 2'd2;
  localparam logic [1:0] CFG_FRAME_HEIGHT     = 2'd3;

  // Configuration reset values
  localparam logic [31:0] CYCLES_PER_FRAME_RST = 32'd133333;
  localparam logic [2:0]  IRQ_LEVEL_RST        = 3'd0;
  localparam logic [15:0] FRAME_WIDTH_RST      = 16'd320;
  localparam logic [15:0] FRAME_HEIGHT_RST     = 16'd240;

  // Register word selects (byte offset bits [2:1] within the register window)
  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_STATUS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // Byte-lane masks
  localparam logic [15:0] HI_MASK = 16'hFF00;
  localparam logic [15:0] LO_MASK = 16'h00FF;

  // Control and status bits
  localparam int unsigned CTRL_DISPLAY_EN = 0;
  localparam int unsigned CTRL_VBLANK_IE  = 1;
  localparam int unsigned STAT_VBLANK     = 0;

  // Address decode of one access
  typedef struct packed {
    logic       vram;     // hits video memory
    logic       pal;      // hits palette
    logic       regs;     // hits register window
    logic       vlo;      // video memory byte offset bit 0
    logic       plo;      // palette byte offset bit 0
    logic [2:0] reg_rel;  // byte offset within register window
  } dec_t;

endpackage

// ----- design/framebuffer_video_registers.sv -----
// Framebuffer video register block: bus slave with video memory, palette and vblank timer.
//
// Each access or tick is handled in two steps: on acceptance the video memory banks and
// the palette memory are read; in the update cycle the result is merged, written back and
// loaded into the result register, waiting while a result is still unread. One item is in
// flight at a time, so no new item is taken before the last one's update cycle. Video
// memory is kept as an even-byte and an odd-byte bank so that a word at any byte offset is
// one read of each bank. After reset a clearing pass zeroes both banks, one row per cycle;
// no word is accepted until it finishes, while configuration writes are taken as ever.
module framebuffer_video_registers
  import fbvr_pkg::*;
#(
  parameter int unsigned VRAM_BYTES      = VRAM_BYTES_DEF,
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int unsigned VRAM_BASE       = VRAM_BASE_DEF,
  parameter int unsigned PALETTE_BASE    = PALETTE_BASE_DEF,
  parameter int unsigned REG_BASE        = REG_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // offset[19:0], write_data[35:20], tick_cycles[51:36], zero
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[15:0], irq_out[18:16], zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Bank geometry
  localparam int unsigned VE_DEPTH = (VRAM_BYTES + 1) / 2;
  localparam int unsigned VO_DEPTH = VRAM_BYTES / 2;
  localparam int unsigned VA_W     = (VE_DEPTH > 1) ? $clog2(VE_DEPTH) : 1;
  localparam int unsigned PI_W     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Window bounds in 22 bits so that base plus size never wraps
  localparam logic [21:0] VB   = 22'(VRAM_BASE);
  localparam logic [21:0] VEND = 22'(VRAM_BASE) + 22'(VRAM_BYTES);
  localparam logic [21:0] PB   = 22'(PALETTE_BASE);
  localparam logic [21:0] PEND = 22'(PALETTE_BASE) + 22'(2 * PALETTE_ENTRIES);
  localparam logic [21:0] RB   = 22'(REG_BASE);
  localparam logic [21:0] REND = 22'(REG_BASE) + 22'd8;

  // Configuration registers
  logic [31:0] cycles_per_frame;
  logic [2:0]  irq_level;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  // Control state
  logic [15:0] control_word, control_word_next;
  logic [15:0] status_word, status_word_next;
  logic [31:0] cycle_accumulator, cycle_accumulator_next;
  logic        busy;
  logic        clearing;
  logic [VA_W-1:0] clr_idx;
  logic [PALETTE_ENTRIES-1:0] pal_valid;

  // Item held between the read and the update cycle
  logic [2:0]      it_type;
  logic [15:0]     it_data;
  logic [15:0]     it_cyc;
  dec_t            it_dec;
  logic [VA_W-1:0] it_even_idx;
  logic [VA_W-1:0] it_odd_idx;
  logic [PI_W-1:0] it_pal_idx;

  // Output register
  logic [15:0] out_rd;
  logic [2:0]  out_irq;

  // Memories and their ports
  logic [7:0]  vram_even [VE_DEPTH];
  logic [7:0]  vram_odd  [VO_DEPTH];
  logic [15:0] pal_mem   [PALETTE_ENTRIES];
  logic [7:0]  ve_q, vo_q;
  logic [15:0] pal_q;
  logic        pal_vld_q;
  logic        ve_we, vo_we, pal_we;
  logic [VA_W-1:0] ve_wa, vo_wa, ve_addr, vo_addr;
  logic [7:0]  ve_wd, vo_wd;
  logic [15:0] pal_wd;

  // Input decode
  logic        accept, exec;
  logic [19:0] in_offset;
  logic [21:0] off22, span, vrel, prel, rrel;
  logic [19:0] vrel20;
  logic [20:0] even_sum;
  logic        in_word;
  dec_t            in_dec;
  logic [VA_W-1:0] in_even_idx, in_odd_idx;
  logic [PI_W-1:0] in_pal_idx;

  // Update-cycle values
  logic [15:0] pal_eff, reg_w_word, reg_w_byte, rd_val;
  logic [31:0] acc_sum;
  logic [32:0] acc_diff;

  assign accept   = s_tvalid && s_tready;
  assign exec     = busy && (!m_tvalid || m_tready);
  assign s_tready = !busy && !clearing;
  assign m_tdata  = {5'd0, out_irq, out_rd};

  // Address decode of the incoming word
  always_comb begin
    in_offset = s_tdata[19:0];
    in_word   = (s_tuser == REQ_RD_WORD) || (s_tuser == REQ_WR_WORD);
    off22     = 22'(in_offset);
    span      = in_word ? 22'd2 : 22'd1;
    vrel      = off22 - VB;
    prel      = off22 - PB;
    rrel      = off22 - RB;
    vrel20    = vrel[19:0];
    in_dec.vram    = (off22 >= VB) && (off22 + span <= VEND);
    in_dec.pal     = !in_dec.vram && (off22 >= PB) && (off22 < PEND);
    in_dec.regs    = !in_dec.vram && !in_dec.pal && (off22 >= RB) && (off22 < REND);
    in_dec.vlo     = vrel20[0];
    in_dec.plo     = prel[0];
    in_dec.reg_rel = rrel[2:0];
    // a word at an odd offset takes its low byte from the next even row
    even_sum    = 21'(vrel20) + 21'(in_word && vrel20[0]);
    in_even_idx = even_sum[VA_W:1];
    in_odd_idx  = vrel20[VA_W:1];
    in_pal_idx  = prel[PI_W:1];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_frame <= CYCLES_PER_FRAME_RST;
      irq_level        <= IRQ_LEVEL_RST;
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CYCLES_PER_FRAME: cycles_per_frame <= cfg_data;
        CFG_IRQ_LEVEL:        irq_level        <= cfg_data[2:0];
        CFG_FRAME_WIDTH:      frame_width      <= cfg_data[15:0];
        CFG_FRAME_HEIGHT:     frame_height     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Register word select for reads
  always_comb begin
    case (it_dec.reg_rel[2:1])
      REG_CTRL:   reg_w_byte = control_word;
      REG_STATUS: reg_w_byte = status_word;
      REG_WIDTH:  reg_w_byte = frame_width;
      REG_HEIGHT: reg_w_byte = frame_height;
      default:    reg_w_byte = '0;
    endcase
    reg_w_word = it_dec.reg_rel[0] ? 16'd0 : reg_w_byte;
  end

  // Update cycle: read result, memory write-back, register and timer update; clearing-pass writes
  always_comb begin
    pal_eff  = pal_vld_q ? pal_q : 16'd0;
    acc_sum  = cycle_accumulator + 32'(it_cyc);
    acc_diff = {1'b0, acc_sum} - {1'b0, cycles_per_frame};

    rd_val                 = '0;
    control_word_next      = control_word;
    status_word_next       = status_word;
    cycle_accumulator_next = cycle_accumulator;
    ve_we  = 1'b0;
    vo_we  = 1'b0;
    pal_we = 1'b0;
    ve_wa  = it_even_idx;
    vo_wa  = it_odd_idx;
    ve_wd  = it_data[7:0];
    vo_wd  = it_data[7:0];
    pal_wd = it_data;

    if (clearing) begin
      ve_we = 1'b1;
      vo_we = (32'(clr_idx) < VO_DEPTH);
      ve_wa = clr_idx;
      vo_wa = clr_idx;
      ve_wd = '0;
      vo_wd = '0;
    end else if (exec) begin
      case (it_type)
        REQ_RD_BYTE: begin
          if (it_dec.vram) begin
            rd_val = {8'd0, it_dec.vlo ? vo_q : ve_q};
          end else if (it_dec.pal) begin
            rd_val = it_dec.plo ? (pal_eff & LO_MASK) : {8'd0, pal_eff[15:8]};
          end else if (it_dec.regs) begin
            rd_val = it_dec.reg_rel[0] ? (reg_w_byte & LO_MASK) : {8'd0, reg_w_byte[15:8]};
          end
        end
        REQ_RD_WORD: begin
          if (it_dec.vram) begin
            rd_val = it_dec.vlo ? {vo_q, ve_q} : {ve_q, vo_q};
          end else if (it_dec.pal) begin
            rd_val = pal_eff;
          end else if (it_dec.regs) begin
            rd_val = reg_w_word;
          end
        end
        REQ_WR_BYTE: begin
          if (it_dec.vram) begin
            ve_we = !it_dec.vlo;
            vo_we = it_dec.vlo;
          end else if (it_dec.pal) begin
            pal_we = 1'b1;
            pal_wd = it_dec.plo ? ((pal_eff & HI_MASK) | (it_data & LO_MASK))
                                : ((pal_eff & LO_MASK) | {it_data[7:0], 8'd0});
          end else if (it_dec.regs && it_dec.reg_rel == 3'd1) begin
            control_word_next = (control_word & HI_MASK) | (it_data & LO_MASK);
          end else if (it_dec.regs && it_dec.reg_rel == 3'd0) begin
            control_word_next = (control_word & LO_MASK) | {it_data[7:0], 8'd0};
          end
        end
        REQ_WR_WORD: begin
          if (it_dec.vram) begin
            ve_we = 1'b1;
            vo_we = 1'b1;
            // big-endian: the byte at the access offset is the high byte
            ve_wd = it_dec.vlo ? it_data[7:0] : it_data[15:8];
            vo_wd = it_dec.vlo ? it_data[15:8] : it_data[7:0];
          end else if (it_dec.pal) begin
            pal_we = 1'b1;
          end else if (it_dec.regs && it_dec.reg_rel == 3'd0) begin
            control_word_next = it_data;
          end else if (it_dec.regs && it_dec.reg_rel == 3'd2) begin
            status_word_next = status_word & ~it_data;
          end
        end
        REQ_TICK: begin
          if (control_word[CTRL_DISPLAY_EN]) begin
            if (!acc_diff[32]) begin
              cycle_accumulator_next = acc_diff[31:0];
              status_word_next[STAT_VBLANK] = 1'b1;
            end else begin
              cycle_accumulator_next = acc_sum;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign ve_addr = accept ? in_even_idx : ve_wa;
  assign vo_addr = accept ? in_odd_idx : vo_wa;

  // Even-byte video memory bank, single port
  always_ff @(posedge clk) begin
    if (ve_we) vram_even[ve_addr] <= ve_wd;
    if (accept && in_dec.vram) ve_q <= vram_even[ve_addr];
  end

  // Odd-byte video memory bank, single port
  always_ff @(posedge clk) begin
    if (vo_we) vram_odd[vo_addr] <= vo_wd;
    if (accept && in_dec.vram) vo_q <= vram_odd[vo_addr];
  end

  // Palette memory; read at accept, write back in the update cycle
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[it_pal_idx] <= pal_wd;
    if (accept && in_dec.pal) begin
      pal_q     <= pal_mem[in_pal_idx];
      pal_vld_q <= pal_valid[in_pal_idx];
    end
  end

  // Palette valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (pal_we) begin
      pal_valid[it_pal_idx] <= 1'b1;
    end
  end

  // Held item
  always_ff @(posedge clk) begin
    if (accept) begin
      it_type     <= s_tuser;
      it_data     <= s_tdata[35:20];
      it_cyc      <= s_tdata[51:36];
      it_dec      <= in_dec;
      it_even_idx <= in_even_idx;
      it_odd_idx  <= in_odd_idx;
      it_pal_idx  <= in_pal_idx;
    end
  end

  // Control, clearing pass and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      clearing          <= 1'b1;
      clr_idx           <= '0;
      control_word      <= '0;
      status_word       <= '0;
      cycle_accumulator <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + VA_W'(1);
        if (clr_idx == VA_W'(VE_DEPTH - 1)) clearing <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end
      control_word      <= control_word_next;
      status_word       <= status_word_next;
      cycle_accumulator <= cycle_accumulator_next;
      if (exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      out_rd  <= rd_val;
      out_irq <= (status_word_next[STAT_VBLANK] && control_word_next[CTRL_VBLANK_IE])
                 ? irq_level : 3'd0;
    end
  end

`ifndef SYNTHESIS
  // an accepted word occupies the block until its update cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !s_tready)
    else $error("accepted word did not hold the block busy");

  // no word is taken while video memory is being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready && !busy)
    else $error("word accepted during clearing pass");

  // every update cycle leaves a result waiting
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> m_tvalid)
    else $error("update cycle produced no result");

  // vblank pending is only cleared by a status word write
  a_vblank_clear: assert property (@(posedge clk) disable iff (rst)
    ($fell(status_word[STAT_VBLANK]) && !$past(rst)) |->
      $past(exec && it_type == REQ_WR_WORD && it_dec.regs && it_dec.reg_rel == 3'd2))
    else $error("vblank pending cleared without a status write");
`endif

endmodule
